FILE: rtl/scs_pkg.sv
// scs_pkg: shared types, operation codes and rectangle helpers for the scissor stack
// used by scissor_clip_stack, scs_checker and the testbench; no dependencies

package scs_pkg;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        w;
        logic [14:0]        h;
    } rect_t;

    localparam int RECT_W = $bits(rect_t);

    // negative size counts as zero
    function automatic logic [14:0] clamp_dim(logic signed [15:0] v);
        logic [14:0] r;
        r = v[15] ? 15'd0 : v[14:0];
        return r;
    endfunction

    // one axis of the intersection: returns {edge, size}
    function automatic logic [30:0] axis_clip(logic signed [15:0] a_p, logic [14:0] a_s,
                                              logic signed [15:0] b_p, logic [14:0] b_s);
        logic signed [16:0] a_end;
        logic signed [16:0] b_end;
        logic signed [16:0] lo;
        logic signed [16:0] hi;
        logic signed [16:0] diff;
        logic signed [15:0] p;
        a_end = {a_p[15], a_p} + {2'b00, a_s};
        b_end = {b_p[15], b_p} + {2'b00, b_s};
        p     = (a_p > b_p) ? a_p : b_p;
        lo    = {p[15], p};
        hi    = (a_end < b_end) ? a_end : b_end;
        if (hi < lo)
        begin
            hi = lo;
        end
        diff = hi - lo;
        return {p, diff[14:0]};
    endfunction

    function automatic rect_t clip_intersect(rect_t a, rect_t b);
        logic [30:0] hx;
        logic [30:0] vy;
        rect_t       r;
        hx  = axis_clip(a.x, a.w, b.x, b.w);
        vy  = axis_clip(a.y, a.h, b.y, b.h);
        r.x = hx[30:15];
        r.w = hx[14:0];
        r.y = vy[30:15];
        r.h = vy[14:0];
        return r;
    endfunction

endpackage

FILE: rtl/scs_if.sv
// scs_req_if / scs_rsp_if: valid-ready channels for scissor stack requests and results
// no dependencies

interface scs_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic signed [15:0] rect_w;
    logic signed [15:0] rect_h;

    modport source (output valid, operation, rect_x, rect_y, rect_w, rect_h, input ready);
    modport sink (input valid, operation, rect_x, rect_y, rect_w, rect_h, output ready);
endinterface

interface scs_rsp_if;
    logic               valid;
    logic               ready;
    logic               scissor_on;
    logic signed [15:0] clip_x;
    logic signed [15:0] clip_y;
    logic [14:0]        clip_w;
    logic [14:0]        clip_h;

    modport source (output valid, scissor_on, clip_x, clip_y, clip_w, clip_h, input ready);
    modport sink (input valid, scissor_on, clip_x, clip_y, clip_w, clip_h, output ready);
endinterface

FILE: rtl/scs_ram.sv
// scs_ram: generic single-write, single-read memory with registered read data
// no dependencies

module scs_ram #(
    parameter int WIDTH = 62,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/scissor_clip_stack.sv
// scissor_clip_stack: nested scissor rectangle stack with registered result
// depends on scs_pkg, scs_if (scs_req_if, scs_rsp_if) and scs_ram

// A push is handled in the idle state: the rectangle is clipped against the top entry, which is
// held in a register, written into the stack memory and placed in the result register. A
// pop that leaves at least one entry waits in ST_POP_WAIT for the new top to come out of
// the registered stack memory read and for the result register to be free; any other pop,
// and a clear, finish in the idle state. A clear gives no result. A new request is taken
// in the idle state once the result register is empty or its result is taken in the same
// cycle. A push on a full stack is clipped and reported but not stored.
module scissor_clip_stack #(
    parameter int STACK_DEPTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    scs_req_if.sink   req,
    scs_rsp_if.source rsp
);

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    typedef enum logic {
        ST_IDLE,
        ST_POP_WAIT
    } state_t;

    state_t                state_reg;
    logic [CNT_W-1:0]      depth_reg;
    scs_pkg::rect_t        tos_reg;
    logic                  out_valid_reg;
    logic                  out_on_reg;
    scs_pkg::rect_t        out_rect_reg;

    scs_pkg::rect_t        in_rect;
    scs_pkg::rect_t        push_rect;
    scs_pkg::rect_t        ram_rect;
    logic [scs_pkg::RECT_W-1:0] ram_rdata;
    logic [CNT_W-1:0]      depth_m2;
    logic                  out_free;
    logic                  out_load;
    logic                  in_fire;
    logic                  full;
    logic                  is_push;
    logic                  is_pop;
    logic                  pop_read;
    logic                  ram_we;

    assign out_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) && out_free;
    assign in_fire  = req.valid && req.ready;
    assign full     = (depth_reg == CNT_W'(STACK_DEPTH));
    assign is_push  = (req.operation == scs_pkg::OP_PUSH);
    assign is_pop   = (req.operation == scs_pkg::OP_POP);
    assign depth_m2 = depth_reg - CNT_W'(2);
    assign pop_read = in_fire && is_pop && (depth_reg > CNT_W'(1));
    assign ram_we   = in_fire && is_push && !full;
    assign out_load = (state_reg == ST_IDLE) ? (in_fire && (is_push || is_pop) && !pop_read)
                                             : out_free;

    always_comb
    begin
        in_rect.x = req.rect_x;
        in_rect.y = req.rect_y;
        in_rect.w = scs_pkg::clamp_dim(req.rect_w);
        in_rect.h = scs_pkg::clamp_dim(req.rect_h);
        if (depth_reg != '0)
        begin
            push_rect = scs_pkg::clip_intersect(tos_reg, in_rect);
        end
        else
        begin
            push_rect = in_rect;
        end
    end

    scs_ram #(
        .WIDTH (scs_pkg::RECT_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (depth_reg[ADDR_W-1:0]),
        .wdata (push_rect),
        .re    (pop_read),
        .raddr (depth_m2[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    assign ram_rect = scs_pkg::rect_t'(ram_rdata);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            depth_reg     <= '0;
            tos_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_on_reg    <= 1'b0;
            out_rect_reg  <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        case (req.operation)
                            scs_pkg::OP_PUSH:
                            begin
                                out_on_reg    <= 1'b1;
                                out_rect_reg  <= push_rect;
                                if (!full)
                                begin
                                    depth_reg <= depth_reg + CNT_W'(1);
                                    tos_reg   <= push_rect;
                                end
                            end
                            scs_pkg::OP_POP:
                            begin
                                if (depth_reg > CNT_W'(1))
                                begin
                                    depth_reg <= depth_reg - CNT_W'(1);
                                    state_reg <= ST_POP_WAIT;
                                end
                                else
                                begin
                                    depth_reg     <= '0;
                                    out_on_reg    <= 1'b0;
                                    out_rect_reg  <= '0;
                                end
                            end
                            scs_pkg::OP_CLEAR:
                            begin
                                depth_reg <= '0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_POP_WAIT:
                begin
                    if (out_free)
                    begin
                        out_on_reg    <= 1'b1;
                        out_rect_reg  <= ram_rect;
                        tos_reg       <= ram_rect;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.scissor_on = out_on_reg;
    assign rsp.clip_x     = out_rect_reg.x;
    assign rsp.clip_y     = out_rect_reg.y;
    assign rsp.clip_w     = out_rect_reg.w;
    assign rsp.clip_h     = out_rect_reg.h;

endmodule

FILE: rtl/scs_checker.sv
// scs_checker: port-level assertions for scissor_clip_stack, bound to the top level
// depends on scs_pkg and scissor_clip_stack

module scs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic [1:0]         operation,
    input logic signed [15:0] rect_w,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic               scissor_on,
    input logic signed [15:0] clip_x,
    input logic signed [15:0] clip_y,
    input logic [14:0]        clip_w,
    input logic [14:0]        clip_h
);

    // stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(scissor_on) && $stable(clip_x)
            && $stable(clip_y) && $stable(clip_w) && $stable(clip_h))
        else $error("stalled result changed");

    // push gives an enabled scissor on the next cycle
    a_push_result: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && operation == scs_pkg::OP_PUSH |=> rsp_valid && scissor_on)
        else $error("push gave no active scissor");

    // clipped width never exceeds the requested width
    a_push_width: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && operation == scs_pkg::OP_PUSH
            |=> $past(rect_w[15]) ? (clip_w == 15'd0) : (clip_w <= $past(rect_w[14:0])))
        else $error("clipped width exceeds request");

    // clear gives no result
    a_clear_silent: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && operation == scs_pkg::OP_CLEAR |=> !rsp_valid)
        else $error("clear produced a result");

endmodule

bind scissor_clip_stack scs_checker u_scs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .operation  (req.operation),
    .rect_w     (req.rect_w),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .scissor_on (rsp.scissor_on),
    .clip_x     (rsp.clip_x),
    .clip_y     (rsp.clip_y),
    .clip_w     (rsp.clip_w),
    .clip_h     (rsp.clip_h)
);

FILE: dv/scs_clip_checker.sv
// scs_clip_checker: watches the request and result channels of scissor_clip_stack,
// predicts each result and compares it; depends on scs_pkg and scs_if
`timescale 1ns / 100ps

module scs_clip_checker #(
    parameter int STACK_DEPTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    scs_req_if   req,
    scs_rsp_if   rsp,
    output int   mismatches,
    output int   pending
);

    typedef struct packed {
        logic           on;
        scs_pkg::rect_t rect;
    } scissor_t;

    scs_pkg::rect_t clip_stack [STACK_DEPTH];
    int             depth;
    scissor_t       expected_scissors [$];

    function automatic scs_pkg::rect_t clip_overlap(scs_pkg::rect_t a, scs_pkg::rect_t b);
        int             lft;
        int             upr;
        int             rgt;
        int             btm;
        scs_pkg::rect_t r;
        lft = (int'($signed(a.x)) > int'($signed(b.x))) ? int'($signed(a.x))
                                                        : int'($signed(b.x));
        upr = (int'($signed(a.y)) > int'($signed(b.y))) ? int'($signed(a.y))
                                                        : int'($signed(b.y));
        rgt = int'($signed(a.x)) + int'(a.w);
        if (int'($signed(b.x)) + int'(b.w) < rgt)
        begin
            rgt = int'($signed(b.x)) + int'(b.w);
        end
        btm = int'($signed(a.y)) + int'(a.h);
        if (int'($signed(b.y)) + int'(b.h) < btm)
        begin
            btm = int'($signed(b.y)) + int'(b.h);
        end
        if (rgt < lft)
        begin
            rgt = lft;
        end
        if (btm < upr)
        begin
            btm = upr;
        end
        r.x = 16'(lft);
        r.y = 16'(upr);
        r.w = 15'(rgt - lft);
        r.h = 15'(btm - upr);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        scs_pkg::rect_t area;
        scissor_t       want;
        scissor_t       seen;
        if (!rst_n)
        begin
            depth      = 0;
            mismatches = 0;
            pending    = 0;
            expected_scissors.delete();
        end
        else
        begin
            // request first, so a result in the same cycle still finds its expectation
            if (req.valid && req.ready)
            begin
                case (req.operation)
                    scs_pkg::OP_PUSH:
                    begin
                        area.x = req.rect_x;
                        area.y = req.rect_y;
                        area.w = req.rect_w[15] ? 15'd0 : req.rect_w[14:0];
                        area.h = req.rect_h[15] ? 15'd0 : req.rect_h[14:0];
                        if (depth > 0)
                        begin
                            area = clip_overlap(clip_stack[depth - 1], area);
                        end
                        if (depth < STACK_DEPTH)
                        begin
                            clip_stack[depth] = area;
                            depth++;
                        end
                        want.on   = 1'b1;
                        want.rect = area;
                        expected_scissors.push_back(want);
                    end
                    scs_pkg::OP_POP:
                    begin
                        if (depth > 0)
                        begin
                            depth--;
                        end
                        want = '0;
                        if (depth > 0)
                        begin
                            want.on   = 1'b1;
                            want.rect = clip_stack[depth - 1];
                        end
                        expected_scissors.push_back(want);
                    end
                    scs_pkg::OP_CLEAR:
                    begin
                        depth = 0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (rsp.valid && rsp.ready)
            begin
                seen.on     = rsp.scissor_on;
                seen.rect.x = rsp.clip_x;
                seen.rect.y = rsp.clip_y;
                seen.rect.w = rsp.clip_w;
                seen.rect.h = rsp.clip_h;
                if (expected_scissors.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, %s%0b x=%0d y=%0d w=%0d h=%0d",
                             $time, "actual on=", seen.on, seen.rect.x, seen.rect.y,
                             seen.rect.w, seen.rect.h);
                end
                else
                begin
                    want = expected_scissors.pop_front();
                    if (want.on !== seen.on || want.rect.x !== seen.rect.x ||
                        want.rect.y !== seen.rect.y || want.rect.w !== seen.rect.w ||
                        want.rect.h !== seen.rect.h)
                    begin
                        mismatches++;
                        $display("%0t: scissor mismatch, expected on=%0b x=%0d y=%0d w=%0d h=%0d",
                                 $time, want.on, want.rect.x, want.rect.y, want.rect.w,
                                 want.rect.h);
                        $display("%0t:                   actual   on=%0b x=%0d y=%0d w=%0d h=%0d",
                                 $time, seen.on, seen.rect.x, seen.rect.y, seen.rect.w,
                                 seen.rect.h);
                    end
                end
            end
            pending = expected_scissors.size();
        end
    end

endmodule

FILE: dv/tb_scissor_clip_stack.sv
// tb_scissor_clip_stack: drives push, pop and clear requests into scissor_clip_stack
// with random gaps and stalls; depends on scs_pkg, scs_if and scs_clip_checker
`timescale 1ns / 100ps

module tb_scissor_clip_stack;

    localparam int         STACK_DEPTH = 16;
    localparam int         ITEM_TARGET = 1950;
    localparam int         QUIET_LIMIT = 2000;
    localparam logic [1:0] OP_SPARE    = 2'd3;   // unused code, ignored by the block

    logic clk;
    logic rst_n;
    bit   gaps_on;
    int   sent;
    int   quiet;
    int   mismatches;
    int   pending;

    scs_req_if req_ch ();
    scs_rsp_if rsp_ch ();

    scissor_clip_stack #(
        .STACK_DEPTH(STACK_DEPTH)
    ) DUT (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    scs_clip_checker #(
        .STACK_DEPTH(STACK_DEPTH)
    ) checker_inst (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .mismatches(mismatches),
        .pending   (pending)
    );

    always #2 clk = ~clk;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            rsp_ch.ready <= gaps_on ? ($urandom_range(99) >= 17) : 1'b1;
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
                if (quiet >= QUIET_LIMIT)
                begin
                    $display("tb_scissor_clip_stack failed");
                    $finish;
                end
            end
        end
    end

    task automatic issue(input logic [1:0] op, input logic [15:0] x, input logic [15:0] y,
                         input logic [15:0] w, input logic [15:0] h);
        while (gaps_on && $urandom_range(99) < 17)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid     = 1'b1;
        req_ch.operation = op;
        req_ch.rect_x    = x;
        req_ch.rect_y    = y;
        req_ch.rect_w    = w;
        req_ch.rect_h    = h;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
        @(negedge clk);
        if (op != OP_SPARE)
        begin
            sent++;
        end
    endtask

    // stop requesting until every outstanding result has been taken
    task automatic drain();
        req_ch.valid = 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic rand_rect(output logic [15:0] x, output logic [15:0] y,
                             output logic [15:0] w, output logic [15:0] h);
        int pick;
        pick = $urandom_range(9);
        if (pick < 6)
        begin
            // small rectangles near the origin so nested pushes overlap
            x = 16'(int'($urandom_range(400)) - 200);
            y = 16'(int'($urandom_range(400)) - 200);
            w = 16'(int'($urandom_range(620)) - 20);
            h = 16'(int'($urandom_range(620)) - 20);
        end
        else if (pick < 9)
        begin
            x = 16'($urandom);
            y = 16'($urandom);
            w = 16'($urandom);
            h = 16'($urandom);
        end
        else
        begin
            x = $urandom_range(1) ? 16'h7fff : 16'h8000;
            y = $urandom_range(1) ? 16'h7fff : 16'h8000;
            w = $urandom_range(1) ? 16'h7fff : 16'h8000;
            h = $urandom_range(1) ? 16'h7fff : 16'h8000;
        end
    endtask

    initial
    begin : stimulus
        logic signed [15:0] fill_rects [16][4];
        logic [15:0]        x;
        logic [15:0]        y;
        logic [15:0]        w;
        logic [15:0]        h;
        int                 burst;
        int                 pick;
        int                 n;

        fill_rects = '{
            '{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767},
            '{-16'sd100, -16'sd50, 16'sd30000, 16'sd20000},
            '{16'sd0, 16'sd0, 16'sd1000, 16'sd800},
            '{16'sd10, -16'sd20, 16'sd500, 16'sd500},
            '{-16'sd5000, 16'sd100, 16'sd5200, 16'sd32767},
            '{16'sd50, 16'sd150, 16'sd32767, 16'sd100},
            '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767},
            '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd1},
            '{16'sd100, 16'sd200, -16'sd5, 16'sd7},
            '{16'sd0, 16'sd0, 16'sd0, 16'sd0},
            '{-16'sd1, -16'sd1, 16'sd1, 16'sd1},
            '{16'sd300, 16'sd400, 16'sd10, 16'sd10},
            '{-16'sd32768, 16'sd32767, 16'sd32767, 16'sd0},
            '{16'sd12345, -16'sd12345, -16'sd32768, 16'sd32767},
            '{16'sd1, 16'sd2, 16'sd3, 16'sd4},
            '{-16'sd2, -16'sd3, 16'sd4, 16'sd5}
        };
        clk              = 1'b0;
        rst_n            = 1'b0;
        gaps_on          = 1'b1;
        sent             = 0;
        quiet            = 0;
        burst            = 0;
        req_ch.valid     = 1'b0;
        req_ch.operation = scs_pkg::OP_PUSH;
        req_ch.rect_x    = '0;
        req_ch.rect_y    = '0;
        req_ch.rect_w    = '0;
        req_ch.rect_h    = '0;
        rsp_ch.ready     = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: clear and pop on an empty stack, spare code, fill past full
        issue(scs_pkg::OP_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        issue(scs_pkg::OP_POP, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        issue(OP_SPARE, 16'h1234, 16'h5678, 16'h9abc, 16'hdef0);
        for (int i = 0; i < 16; i++)
        begin
            issue(scs_pkg::OP_PUSH, fill_rects[i][0], fill_rects[i][1], fill_rects[i][2],
                  fill_rects[i][3]);
        end
        issue(scs_pkg::OP_PUSH, 16'd40, 16'd160, 16'd20, 16'd30);
        issue(scs_pkg::OP_POP, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        issue(scs_pkg::OP_CLEAR, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        issue(scs_pkg::OP_POP, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        issue(scs_pkg::OP_PUSH, 16'hfff9, 16'h0009, 16'h8000, 16'hfed4);
        drain();

        // random: mostly nested push runs unwound by pops, some noise and clears
        while (sent < ITEM_TARGET)
        begin
            burst++;
            gaps_on = !(sent > 700 && sent < 1000);
            if (burst % 60 == 30)
            begin
                drain();
            end
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                n = $urandom_range(1, 20);
                repeat (n)
                begin
                    rand_rect(x, y, w, h);
                    issue(scs_pkg::OP_PUSH, x, y, w, h);
                end
                repeat ($urandom_range(0, n + 2))
                begin
                    issue(scs_pkg::OP_POP, 16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom));
                end
            end
            else if (pick < 90)
            begin
                repeat ($urandom_range(1, 8))
                begin
                    rand_rect(x, y, w, h);
                    issue(2'($urandom_range(3)), x, y, w, h);
                end
            end
            else
            begin
                issue(scs_pkg::OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom));
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("tb_scissor_clip_stack passed");
        end
        else
        begin
            $display("tb_scissor_clip_stack failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/scs_pkg.sv
rtl/scs_if.sv
rtl/scs_ram.sv
rtl/scissor_clip_stack.sv
rtl/scs_checker.sv
dv/scs_clip_checker.sv
dv/tb_scissor_clip_stack.sv
